FILE: rtl/u8u16_pkg.sv
package u8u16_pkg;

    localparam int unsigned MaxUnits = 4;

    typedef logic [15:0] unit_t;
    typedef logic [30:0] acc_t;
    typedef logic [2:0]  pend_t;

    // One decoded value, expanded into one unit or a surrogate pair.
    typedef struct packed {
        unit_t first;
        unit_t second;
        logic  pair;
    } expand_t;

    // All units caused by one input byte.
    typedef struct packed {
        unit_t [MaxUnits-1:0] units;
        logic  [2:0]          num;
    } unit_list_t;

    function automatic expand_t expand_value(input acc_t v);
        expand_t     e;
        logic [10:0] top;
        top      = v[20:10] - 11'h040;
        e.pair   = (v >= 31'h0001_0000) && (v <= 31'h0010_FFFF);
        e.first  = e.pair ? (16'hD800 | {6'd0, top[9:0]}) : v[15:0];
        e.second = 16'hDC00 | {6'd0, v[9:0]};
        return e;
    endfunction

endpackage

FILE: rtl/utf8_to_utf16_stream_top.sv
// UTF-8 to UTF-16 stream transcoder.
// Input channel: in_valid/in_ready with data_byte and final_byte, one source
// byte per transaction; final_byte marks the last byte of a string.
// Output channel: out_valid/out_ready with code_unit, run_end and string_end.
// run_end flags the last unit caused by one input byte, string_end the last
// unit of the string. A byte causes zero to four units.
// A byte taken from the input channel lands in the input register, is
// decoded into the unit buffer once the buffer is free, and its first unit
// is then offered on the output channel.
// Throughput: one byte per cycle while each byte yields at most one unit and
// out_ready stays high; a byte that yields more units holds the unit buffer
// until its last unit is taken, as it drains one unit per output transaction.
// A stalled receiver holds the buffer; the input register then fills and
// in_ready drops until the buffer's last unit is taken.
// Reset clears the accumulator, the pending count and both valid flags.
module utf8_to_utf16_stream_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        run_end,
    output logic        string_end
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [7:0]                  in_byte_reg;
    logic                        in_fin_reg;

    u8u16_pkg::acc_t             acc_reg;
    u8u16_pkg::acc_t             acc_next;
    u8u16_pkg::pend_t            cnt_reg;
    u8u16_pkg::pend_t            cnt_next;

    u8u16_pkg::unit_list_t       list;
    u8u16_pkg::unit_t [u8u16_pkg::MaxUnits-1:0] units_reg;
    logic [2:0]                  num_reg;
    logic [1:0]                  idx_reg;
    logic [1:0]                  idx_next;
    logic                        buf_valid_reg;
    logic                        buf_valid_next;
    logic                        buf_fin_reg;

    logic                        last;
    logic                        buf_free;
    logic                        advance;

    u8u16_decode u_decode (
        .data_byte  (in_byte_reg),
        .final_byte (in_fin_reg),
        .acc        (acc_reg),
        .cnt        (cnt_reg),
        .acc_next   (acc_next),
        .cnt_next   (cnt_next),
        .list       (list)
    );

    assign last     = (({1'b0, idx_reg} + 3'd1) == num_reg);
    assign buf_free = !buf_valid_reg || (out_ready && last);
    assign advance  = in_valid_reg && buf_free;
    assign in_ready = !in_valid_reg || advance;

    assign out_valid  = buf_valid_reg;
    assign code_unit  = units_reg[idx_reg];
    assign run_end    = last;
    assign string_end = last && buf_fin_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        idx_next       = idx_reg;
        if (advance)
        begin
            // zero-unit bytes only update the state
            buf_valid_next = (list.num != 3'd0);
            idx_next       = 2'd0;
        end
        else if (buf_valid_reg && out_ready)
        begin
            if (last)
            begin
                buf_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            buf_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            num_reg       <= 3'd0;
            acc_reg       <= '0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            buf_valid_reg <= buf_valid_next;
            idx_reg       <= idx_next;
            if (advance)
            begin
                num_reg <= list.num;
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_fin_reg  <= final_byte;
        end
        if (advance)
        begin
            units_reg   <= list.units;
            buf_fin_reg <= in_fin_reg;
        end
    end

    a_buf_index: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> (num_reg != 3'd0) && ({1'b0, idx_reg} < num_reg))
        else $error("unit buffer index out of range");

    a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_end)
        else $error("string_end without run_end");

    a_string_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_fin_reg |=> (acc_reg == '0) && (cnt_reg == 3'd0))
        else $error("state not cleared after final byte");

    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd5)
        else $error("pending count out of range");

endmodule

FILE: rtl/u8u16_decode.sv
module u8u16_decode (
    input  logic [7:0]             data_byte,
    input  logic                   final_byte,
    input  u8u16_pkg::acc_t        acc,
    input  u8u16_pkg::pend_t       cnt,
    output u8u16_pkg::acc_t        acc_next,
    output u8u16_pkg::pend_t       cnt_next,
    output u8u16_pkg::unit_list_t  list
);

    logic                 is_cont;
    logic                 flush;
    logic                 emit_new;
    u8u16_pkg::acc_t      acc_step;
    u8u16_pkg::pend_t     cnt_step;
    u8u16_pkg::expand_t   e_old;
    u8u16_pkg::expand_t   e_new;
    logic [2:0]           base;

    assign is_cont = (data_byte[7:6] == 2'b10);
    assign flush   = (cnt != 3'd0) && !is_cont;

    always_comb
    begin
        acc_step = acc;
        cnt_step = 3'd0;
        if ((cnt != 3'd0) && is_cont)
        begin
            acc_step = {acc[24:0], data_byte[5:0]};
            cnt_step = cnt - 3'd1;
        end
        else if (data_byte[7] == 1'b0)
        begin
            acc_step = {24'd0, data_byte[6:0]};
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            acc_step = {26'd0, data_byte[4:0]};
            cnt_step = 3'd1;
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            acc_step = {27'd0, data_byte[3:0]};
            cnt_step = 3'd2;
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            acc_step = {28'd0, data_byte[2:0]};
            cnt_step = 3'd3;
        end
        else if (data_byte[7:2] == 6'b111110)
        begin
            acc_step = {29'd0, data_byte[1:0]};
            cnt_step = 3'd4;
        end
        else if (data_byte[7:1] == 7'b1111110)
        begin
            acc_step = {30'd0, data_byte[0]};
            cnt_step = 3'd5;
        end
        // invalid lead: keep the accumulator, nothing pending
    end

    // A finished sequence, a single-byte value, a repeated value, or an
    // end-of-string flush all emit the updated accumulator.
    assign emit_new = (cnt_step == 3'd0) || final_byte;

    assign e_old = u8u16_pkg::expand_value(acc);
    assign e_new = u8u16_pkg::expand_value(acc_step);

    always_comb
    begin
        list.units = '0;
        base       = 3'd0;
        if (flush)
        begin
            list.units[0] = e_old.first;
            list.units[1] = e_old.second;
            base          = e_old.pair ? 3'd2 : 3'd1;
        end
        if (emit_new)
        begin
            case (base)
                3'd0:
                begin
                    list.units[0] = e_new.first;
                    list.units[1] = e_new.second;
                end
                3'd1:
                begin
                    list.units[1] = e_new.first;
                    list.units[2] = e_new.second;
                end
                default:
                begin
                    list.units[2] = e_new.first;
                    list.units[3] = e_new.second;
                end
            endcase
        end
        list.num = base + (emit_new ? (e_new.pair ? 3'd2 : 3'd1) : 3'd0);
    end

    assign acc_next = final_byte ? '0 : acc_step;
    assign cnt_next = final_byte ? 3'd0 : cnt_step;

endmodule
